/* rtl/qpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature position counter package
// Shared types, field widths and codes for the quadrature position counter.
// ----------------------------------------------------------------------------
package qpc_pkg;

  localparam int TGT_W      = 11;
  localparam int REV_W      = 7;
  localparam int TIME_W     = 16;
  localparam int DELTA_W    = 11;
  localparam int SKIP_W     = 16;
  localparam int POS_OUT_W  = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 72;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REVS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd2;

  localparam logic signed [TGT_W-1:0] TARGET_RESET   = -11'sd1;
  localparam logic [TIME_W-1:0]       INTERVAL_RESET = 16'd6250;

  localparam logic signed [1:0] DIR_NONE = 2'sb00;
  localparam logic signed [1:0] DIR_UP   = 2'sb01;
  localparam logic signed [1:0] DIR_DOWN = 2'sb11;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_START  = 2'd2
  } action_t;

  typedef struct packed {
    action_t             action;
    logic                sensor_a;
    logic                sensor_b;
    logic [TIME_W-1:0]   timestamp;
  } item_t;

  typedef struct packed {
    logic [POS_OUT_W-1:0]      position;
    logic signed [1:0]         direction;
    logic                      stop_request;
    logic                      window_updated;
    logic signed [DELTA_W-1:0] window_count_delta;
    logic [TIME_W-1:0]         window_time_delta;
    logic [SKIP_W-1:0]         skip_total;
    logic [REV_W-1:0]          revolutions_left;
    logic                      history_aged;
  } result_t;

endpackage

/* rtl/qpc_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature position counter input stage
// Registers one incoming item and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module qpc_in_stage
  import qpc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_valid,
  output logic  s_ready,
  input  item_t s_item,
  input  logic  advance,
  output logic  item_valid,
  output item_t item
);

  logic valid;

  assign s_ready    = !valid || advance;
  assign item_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_valid && s_ready) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      item <= s_item;
    end
  end

endmodule

/* rtl/qpc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature position counter core
// Holds the decoder state and computes one item's result in a single pass.
// ----------------------------------------------------------------------------
module qpc_core
  import qpc_pkg::*;
#(
  parameter int COUNTS_PER_REV = 1024,
  parameter int WINDOW_COUNTS  = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  item_valid,
  input  item_t                 item,
  input  logic                  out_free,
  output logic                  advance,
  output logic                  res_valid,
  output result_t               res
);

  localparam int PW = $clog2(COUNTS_PER_REV);
  localparam int CW = (PW > POS_OUT_W) ? PW : POS_OUT_W;
  localparam logic [PW-1:0] POS_MAX = PW'(COUNTS_PER_REV - 1);
  localparam logic signed [DELTA_W-1:0] WIN_HI = DELTA_W'(WINDOW_COUNTS);
  localparam logic signed [DELTA_W-1:0] WIN_LO = -DELTA_W'(WINDOW_COUNTS);

  // Configuration registers.
  logic signed [TGT_W-1:0] target;
  logic [REV_W-1:0]        rev_preset;
  logic [TIME_W-1:0]       stale_limit;

  // Decoder state. Count history is kept as the current position plus the
  // differences between neighboring entries, which wrapping never changes.
  logic [1:0]                prev_lines, prev_lines_next;
  logic signed [1:0]         prev_dir, prev_dir_next;
  logic [PW-1:0]             pos, pos_next;
  logic signed [DELTA_W-1:0] d21, d21_next;
  logic signed [DELTA_W-1:0] d10, d10_next;
  logic [TIME_W-1:0]         t0, t0_next, t1, t1_next, t2, t2_next;
  logic [REV_W-1:0]          turns, turns_next;
  logic [SKIP_W-1:0]         skip, skip_next;
  logic                      running, running_next;

  logic                      has_result;
  logic [1:0]                lines, changed;
  logic                      is_skip;
  logic signed [1:0]         dir, dir_a;
  logic [PW-1:0]             pos_a, pos_b;
  logic                      hit_a, hit_b;
  logic [REV_W-1:0]          turns_a, turns_b;
  logic                      stop_a, stop_b;
  logic signed [DELTA_W-1:0] d21_step;
  logic                      win_shift;
  logic [TIME_W-1:0]         dt2, t1_aged;
  logic                      stale;
  logic                      stop_req, updated, aged;
  logic signed [1:0]         dir_out;

  function automatic logic [PW-1:0] step_pos(input logic [PW-1:0] p,
                                             input logic signed [1:0] d);
    logic [PW-1:0] r;
    r = p;
    if (d == DIR_UP) begin
      r = (p == POS_MAX) ? '0 : p + PW'(1);
    end else if (d == DIR_DOWN) begin
      r = (p == '0) ? POS_MAX : p - PW'(1);
    end
    return r;
  endfunction

  function automatic logic target_hit(input logic [PW-1:0] p,
                                      input logic signed [TGT_W-1:0] t);
    return !t[TGT_W-1] && (CW'(p) == CW'(t[TGT_W-2:0]));
  endfunction

  function automatic logic signed [DELTA_W-1:0] ext_dir(input logic signed [1:0] d);
    return {{(DELTA_W-2){d[1]}}, d};
  endfunction

  assign advance = item_valid && out_free;

  always_comb begin
    lines   = {item.sensor_b, item.sensor_a};
    changed = lines ^ prev_lines;
    is_skip = (changed == 2'b11);
    case (changed)
      2'b01:   dir = (item.sensor_a ^ item.sensor_b) ? DIR_UP : DIR_DOWN;
      2'b10:   dir = (!item.sensor_a ^ item.sensor_b) ? DIR_UP : DIR_DOWN;
      default: dir = prev_dir;
    endcase
    dir_a = is_skip ? prev_dir : DIR_NONE;

    // A double transition applies the last direction once before the
    // regular step; both applications check the target.
    pos_a   = step_pos(pos, dir_a);
    hit_a   = is_skip && target_hit(pos_a, target);
    turns_a = turns;
    stop_a  = 1'b0;
    if (hit_a) begin
      if (turns != '0) begin
        turns_a = turns - REV_W'(1);
      end else begin
        stop_a = 1'b1;
      end
    end
    pos_b   = step_pos(pos_a, dir);
    hit_b   = target_hit(pos_b, target);
    turns_b = turns_a;
    stop_b  = stop_a;
    if (hit_b) begin
      if (turns_a != '0) begin
        turns_b = turns_a - REV_W'(1);
      end else begin
        stop_b = 1'b1;
      end
    end
    d21_step  = d21 + ext_dir(dir_a) + ext_dir(dir);
    win_shift = (d21_step >= WIN_HI) || (d21_step <= WIN_LO);

    dt2     = item.timestamp - t2;
    stale   = running && (dt2 > stale_limit);
    t1_aged = t2 - stale_limit;

    prev_lines_next = prev_lines;
    prev_dir_next   = prev_dir;
    pos_next        = pos;
    d21_next        = d21;
    d10_next        = d10;
    t0_next         = t0;
    t1_next         = t1;
    t2_next         = t2;
    turns_next      = turns;
    skip_next       = skip;
    running_next    = running;
    has_result      = 1'b0;
    stop_req        = 1'b0;
    updated         = 1'b0;
    aged            = 1'b0;
    dir_out         = DIR_NONE;

    case (item.action)
      ACT_SAMPLE: begin
        if (changed != 2'b00) begin
          has_result      = 1'b1;
          dir_out         = dir;
          prev_lines_next = lines;
          prev_dir_next   = dir;
          pos_next        = pos_b;
          turns_next      = turns_b;
          stop_req        = stop_b;
          t2_next         = item.timestamp;
          if (stop_b) begin
            running_next = 1'b0;
          end
          if (is_skip) begin
            skip_next = skip + SKIP_W'(1);
          end
          if (win_shift) begin
            d10_next = d21_step;
            d21_next = '0;
            t0_next  = t1;
            t1_next  = item.timestamp;
            updated  = 1'b1;
          end else begin
            d21_next = d21_step;
          end
        end
      end
      ACT_TICK: begin
        has_result = 1'b1;
        if (stale) begin
          t1_next  = t1_aged;
          t0_next  = t1_aged - stale_limit;
          d21_next = '0;
          d10_next = '0;
          aged     = 1'b1;
        end
      end
      ACT_START: begin
        has_result    = 1'b1;
        running_next  = 1'b1;
        prev_dir_next = DIR_NONE;
        t0_next       = TIME_W'(0) - {stale_limit[TIME_W-2:0], 1'b0};
        t1_next       = TIME_W'(0) - stale_limit;
        t2_next       = '0;
        skip_next     = '0;
        turns_next    = rev_preset;
      end
      default: begin
        has_result = 1'b0;
      end
    endcase

    res_valid              = advance && has_result;
    res.position           = POS_OUT_W'(pos_next);
    res.direction          = dir_out;
    res.stop_request       = stop_req;
    res.window_updated     = updated;
    res.window_count_delta = d10_next;
    res.window_time_delta  = t1_next - t0_next;
    res.skip_total         = skip_next;
    res.revolutions_left   = turns_next;
    res.history_aged       = aged;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target      <= TARGET_RESET;
      rev_preset  <= '0;
      stale_limit <= INTERVAL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET:   target      <= cfg_data[TGT_W-1:0];
        REG_REVS:     rev_preset  <= cfg_data[REV_W-1:0];
        REG_INTERVAL: stale_limit <= cfg_data[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_lines <= '0;
      prev_dir   <= DIR_NONE;
      pos        <= '0;
      d21        <= '0;
      d10        <= '0;
      t0         <= '0;
      t1         <= '0;
      t2         <= '0;
      turns      <= '0;
      skip       <= '0;
      running    <= 1'b0;
    end else if (advance) begin
      prev_lines <= prev_lines_next;
      prev_dir   <= prev_dir_next;
      pos        <= pos_next;
      d21        <= d21_next;
      d10        <= d10_next;
      t0         <= t0_next;
      t1         <= t1_next;
      t2         <= t2_next;
      turns      <= turns_next;
      skip       <= skip_next;
      running    <= running_next;
    end
  end

endmodule

/* rtl/qpc_out_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature position counter output stage
// Result register that holds a finished item until the sink takes it.
// ----------------------------------------------------------------------------
module qpc_out_stage
  import qpc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_data,
  output logic    out_free,
  output logic    m_valid,
  input  logic    m_ready,
  output result_t m_data
);

  logic valid;

  assign out_free = !valid || m_ready;
  assign m_valid  = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (m_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_data <= load_data;
    end
  end

endmodule

/* rtl/quadrature_position_counter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature position counter
// Decodes quadrature line samples, timer ticks and start commands into a
// position within one revolution, with target stop and speed windows.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Content
// s_*       in         s_tvalid/s_tready   sensor samples, ticks, start
// m_*       out        m_tvalid/m_tready   position and status results
// cfg_*     in         cfg_we              target, revolutions, interval
//
// One item is accepted per cycle while the result register is free; its
// result is loaded into that register and then offered on m_tdata (input
// register, then result register). The single-pass state update in the
// core sets the one item per cycle figure. A sample with unchanged lines and
// action code 3 produce no result. When m_tready is low with a result
// waiting, one more item is held in the input register and then s_tready
// drops. Reset is synchronous and clears all but the data registers.
// ----------------------------------------------------------------------------
module quadrature_position_counter
  import qpc_pkg::*;
#(
  parameter int COUNTS_PER_REV = 1024,
  parameter int WINDOW_COUNTS  = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [0] sensor_a, [1] sensor_b, [17:2] timestamp, [23:18] zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [1:0] action
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [9:0] position, [11:10] direction, [12] stop_request, [13] window_updated,
  // [24:14] window_count_delta, [40:25] window_time_delta,
  // [56:41] skip_total, [63:57] revolutions_left, [64] history_aged, [71:65] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  item_t   s_item, item;
  logic    item_valid, advance, out_free, res_valid;
  result_t res, m_res;

  always_comb begin
    s_item.action    = action_t'(s_tuser);
    s_item.sensor_a  = s_tdata[0];
    s_item.sensor_b  = s_tdata[1];
    s_item.timestamp = s_tdata[TIME_W+1:2];
  end

  qpc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_tvalid),
    .s_ready    (s_tready),
    .s_item     (s_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  qpc_core #(
    .COUNTS_PER_REV (COUNTS_PER_REV),
    .WINDOW_COUNTS  (WINDOW_COUNTS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .advance    (advance),
    .res_valid  (res_valid),
    .res        (res)
  );

  qpc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .load_data (res),
    .out_free  (out_free),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .m_data    (m_res)
  );

  assign m_tdata = {7'd0, m_res.history_aged, m_res.revolutions_left, m_res.skip_total,
                    m_res.window_time_delta, m_res.window_count_delta,
                    m_res.window_updated, m_res.stop_request, m_res.direction,
                    m_res.position};

endmodule
